[src/sat_pkg.sv]
// Shared types and constants for the sorted address table.
// Holds field widths, request and status codes, and the controller/datapath
// command and status structs. Depends on nothing.
package sat_pkg;

  localparam int CAPACITY_DEF = 512;

  localparam int ADDR_W  = 32;
  localparam int FLAG_W  = 4;
  localparam int KIND_W  = 2;
  localparam int ST_W    = 3;
  localparam int INDEX_W = 9;
  localparam int COUNT_W = 10;

  localparam logic [KIND_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] REQ_LOOKUP = 2'd2;

  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_DELETED  = 3'd3;
  localparam logic [ST_W-1:0] ST_DEL_MISS = 3'd4;
  localparam logic [ST_W-1:0] ST_HIT      = 3'd5;
  localparam logic [ST_W-1:0] ST_MISS     = 3'd6;

  typedef struct packed {
    logic            load_req;
    logic            srch_rd;
    logic            srch_upd;
    logic            chk_rd;
    logic            chk_eval;
    logic            up_init;
    logic            up_rd;
    logic            up_wr;
    logic            up_fin;
    logic            dn_init;
    logic            dn_rd;
    logic            dn_wr;
    logic            dn_fin;
    logic            out_load;
    logic [ST_W-1:0] st;
  } sat_cmd_t;

  typedef struct packed {
    logic search_more;
    logic found;
    logic is_insert;
    logic is_delete;
    logic full;
    logic up_more;
    logic dn_more;
    logic out_busy;
  } sat_sts_t;

endpackage

[src/sorted_address_table.sv]
// Top level of the sorted address table.
// Joins the controller (sat_ctrl) and the datapath (sat_datapath); uses sat_pkg.
//
// Usage: one request beat (req_type, ip_addr, enable_flags) enters on the
// input channel when in_valid is high and in_stall is low. Each request gives
// exactly one result beat (status, entry_index, entry_flags, entry_count) on
// the output channel, taken when out_valid is high and out_stall is low.
// One request is worked on at a time. A binary search over the n stored
// entries waits, at each probe, for a registered memory read (states S_RD
// and S_CMP), and is followed by a presence check (C_EVAL) and a decision
// (DECIDE) before the result beat. An insert or delete also moves every entry
// behind the position, each by a read and a write through the memory ports.
// The result sits in an output register, so the next request is accepted
// while an earlier result is still stalled; a finished request then waits
// until that register is free. Reset empties the table at once: the count
// drops to zero and no memory clearing pass is needed.
module sorted_address_table #(
  parameter int CAPACITY = sat_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sat_pkg::KIND_W-1:0]   req_type,
  input  logic [sat_pkg::ADDR_W-1:0]   ip_addr,
  input  logic [sat_pkg::FLAG_W-1:0]   enable_flags,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sat_pkg::ST_W-1:0]     status,
  output logic [sat_pkg::INDEX_W-1:0]  entry_index,
  output logic [sat_pkg::FLAG_W-1:0]   entry_flags,
  output logic [sat_pkg::COUNT_W-1:0]  entry_count
);
  import sat_pkg::*;

  sat_cmd_t cmd;
  sat_sts_t sts;

  sat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sat_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req_type     (req_type),
    .ip_addr      (ip_addr),
    .enable_flags (enable_flags),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .status       (status),
    .entry_index  (entry_index),
    .entry_flags  (entry_flags),
    .entry_count  (entry_count),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

[src/sat_ctrl.sv]
// Controller state machine for the sorted address table.
// Sequences search, presence check, entry shifting and result hand-off.
// Depends on sat_pkg.
module sat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sat_pkg::sat_sts_t  sts,
  output sat_pkg::sat_cmd_t  cmd
);
  import sat_pkg::*;

  typedef enum logic [3:0] {
    IDLE, S_RD, S_CMP, C_EVAL, DECIDE, UP_RD, UP_WR, DN_RD, DN_WR, FINISH
  } state_t;

  state_t          state, state_next;
  logic [ST_W-1:0] st_code, st_code_next;

  always_comb begin
    cmd          = '0;
    cmd.st       = st_code;
    state_next   = state;
    st_code_next = st_code;
    in_stall     = (state != IDLE);
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_RD;
        end
      end
      S_RD: begin
        if (sts.search_more) begin
          cmd.srch_rd = 1'b1;
          state_next  = S_CMP;
        end else begin
          cmd.chk_rd = 1'b1;
          state_next = C_EVAL;
        end
      end
      S_CMP: begin
        cmd.srch_upd = 1'b1;
        state_next   = S_RD;
      end
      C_EVAL: begin
        cmd.chk_eval = 1'b1;
        state_next   = DECIDE;
      end
      DECIDE: begin
        priority if (sts.is_insert) begin
          priority if (sts.found) begin
            st_code_next = ST_PRESENT;
            state_next   = FINISH;
          end else if (sts.full) begin
            st_code_next = ST_FULL;
            state_next   = FINISH;
          end else begin
            cmd.up_init = 1'b1;
            state_next  = UP_RD;
          end
        end else if (sts.is_delete) begin
          if (sts.found) begin
            cmd.dn_init = 1'b1;
            state_next  = DN_RD;
          end else begin
            st_code_next = ST_DEL_MISS;
            state_next   = FINISH;
          end
        end else begin
          st_code_next = sts.found ? ST_HIT : ST_MISS;
          state_next   = FINISH;
        end
      end
      UP_RD: begin
        if (sts.up_more) begin
          cmd.up_rd  = 1'b1;
          state_next = UP_WR;
        end else begin
          cmd.up_fin   = 1'b1;
          st_code_next = ST_INSERTED;
          state_next   = FINISH;
        end
      end
      UP_WR: begin
        cmd.up_wr  = 1'b1;
        state_next = UP_RD;
      end
      DN_RD: begin
        if (sts.dn_more) begin
          cmd.dn_rd  = 1'b1;
          state_next = DN_WR;
        end else begin
          cmd.dn_fin   = 1'b1;
          st_code_next = ST_DELETED;
          state_next   = FINISH;
        end
      end
      DN_WR: begin
        cmd.dn_wr  = 1'b1;
        state_next = DN_RD;
      end
      FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      st_code <= ST_INSERTED;
    end else begin
      state   <= state_next;
      st_code <= st_code_next;
    end
  end

endmodule

[src/sat_datapath.sv]
// Datapath for the sorted address table: entry memory, search bounds,
// shift pointer, entry count and the output beat register.
// Depends on sat_pkg.
module sat_datapath #(
  parameter int CAPACITY = sat_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [sat_pkg::KIND_W-1:0]   req_type,
  input  logic [sat_pkg::ADDR_W-1:0]   ip_addr,
  input  logic [sat_pkg::FLAG_W-1:0]   enable_flags,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [sat_pkg::ST_W-1:0]     status,
  output logic [sat_pkg::INDEX_W-1:0]  entry_index,
  output logic [sat_pkg::FLAG_W-1:0]   entry_flags,
  output logic [sat_pkg::COUNT_W-1:0]  entry_count,
  input  sat_pkg::sat_cmd_t            cmd,
  output sat_pkg::sat_sts_t            sts
);
  import sat_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WORD_W = ADDR_W + FLAG_W;

  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] rdata;
  logic [IDX_W-1:0]  raddr;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;

  logic [ADDR_W-1:0] key;
  logic [KIND_W-1:0] kind;
  logic [FLAG_W-1:0] req_flg;
  logic [CNT_W-1:0]  lo, hi, mid, p, count;
  logic              found;
  logic [FLAG_W-1:0] fnd_flg;

  logic [CNT_W-1:0]  mid_calc, p_dec, p_inc;
  logic [ADDR_W-1:0] rd_addr;
  logic [FLAG_W-1:0] rd_flg;
  logic [31:0]       lo_ext, count_ext;

  assign mid_calc = lo + ((hi - lo) >> 1);
  assign p_dec    = p - CNT_W'(1);
  assign p_inc    = p + CNT_W'(1);
  assign rd_addr  = rdata[WORD_W-1:FLAG_W];
  assign rd_flg   = rdata[FLAG_W-1:0];
  assign lo_ext    = 32'(lo);
  assign count_ext = 32'(count);

  always_comb begin
    priority if (cmd.srch_rd) begin
      raddr = mid_calc[IDX_W-1:0];
    end else if (cmd.up_rd) begin
      raddr = p_dec[IDX_W-1:0];
    end else if (cmd.dn_rd) begin
      raddr = p_inc[IDX_W-1:0];
    end else begin
      raddr = lo[IDX_W-1:0];
    end
  end

  always_comb begin
    we    = cmd.up_wr | cmd.dn_wr | cmd.up_fin;
    waddr = cmd.up_fin ? lo[IDX_W-1:0] : p[IDX_W-1:0];
    wdata = cmd.up_fin ? {key, req_flg} : rdata;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      key     <= ip_addr;
      kind    <= req_type;
      req_flg <= enable_flags;
      lo      <= '0;
      hi      <= count;
    end
    if (cmd.srch_rd) begin
      mid <= mid_calc;
    end
    if (cmd.srch_upd) begin
      if (rd_addr < key) begin
        lo <= mid + CNT_W'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.chk_eval) begin
      found   <= (lo < count) && (rd_addr == key);
      fnd_flg <= rd_flg;
    end
    if (cmd.up_init) begin
      p <= count;
    end else if (cmd.dn_init) begin
      p <= lo;
    end else if (cmd.up_wr) begin
      p <= p_dec;
    end else if (cmd.dn_wr) begin
      p <= p_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.up_fin) begin
      count <= count + CNT_W'(1);
    end else if (cmd.dn_fin) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= cmd.st;
      entry_count <= count_ext[COUNT_W-1:0];
      unique case (cmd.st)
        ST_PRESENT, ST_HIT, ST_DELETED: begin
          entry_index <= lo_ext[INDEX_W-1:0];
          entry_flags <= fnd_flg;
        end
        ST_INSERTED: begin
          entry_index <= lo_ext[INDEX_W-1:0];
          entry_flags <= req_flg;
        end
        default: begin
          entry_index <= '0;
          entry_flags <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts.search_more = (lo < hi);
    sts.found       = found;
    sts.is_insert   = (kind == REQ_INSERT);
    sts.is_delete   = (kind == REQ_DELETE);
    sts.full        = (count == CNT_W'(CAPACITY));
    sts.up_more     = (p > lo);
    sts.dn_more     = (p_inc < count);
    sts.out_busy    = out_valid & out_stall;
  end

endmodule
